>>> hdl/chea_pkg.sv
// ----------------------------------------------------------------------------
// chea_pkg
// Types and constants shared by the channel hit and energy accumulator.
// ----------------------------------------------------------------------------
package chea_pkg;

    localparam int CHANNELS_DEF = 8736;
    localparam int SUM_BITS_DEF = 32;

    localparam int CMD_W   = 3;
    localparam int CHAN_W  = 14;
    localparam int EN_W    = 20;
    localparam int TIME_W  = 20;
    localparam int EVT_W   = 24;
    localparam int COUNT_W = 24;
    localparam int OSUM_W  = 32;
    localparam int TOTAL_W = 40;
    localparam int CFG_W   = 25;
    localparam int CFG_IDX_W = 3;

    // command codes
    localparam logic [CMD_W-1:0] CMD_CLEAR   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_RECORD  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_READ    = 3'd2;
    localparam logic [CMD_W-1:0] CMD_EXCLUDE = 3'd3;
    localparam logic [CMD_W-1:0] CMD_INCLUDE = 3'd4;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TIME_LOW    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TIME_HIGH   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ENERGY_LOW  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ENERGY_HIGH = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_EVENT_LOW   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_EVENT_HIGH  = 3'd5;

    // register reset values
    localparam logic [15:0] TIME_LOW_RST    = 16'hF800;    // -2048
    localparam logic [15:0] TIME_HIGH_RST   = 16'hFFFF;
    localparam logic [15:0] ENERGY_LOW_RST  = 16'h0000;
    localparam logic [16:0] ENERGY_HIGH_RST = 17'h1FFFF;
    localparam logic [23:0] EVENT_LOW_RST   = 24'h000000;
    localparam logic [24:0] EVENT_HIGH_RST  = 25'h1FFFFFF;

    typedef struct packed {
        logic [CMD_W-1:0]         cmd;
        logic [CHAN_W-1:0]        channel;
        logic [EN_W-1:0]          energy;
        logic signed [TIME_W-1:0] hit_time;
        logic [EVT_W-1:0]         event_number;
    } hit_t;

    typedef struct packed {
        logic                 accepted;
        logic [COUNT_W-1:0]   channel_count;
        logic [OSUM_W-1:0]    channel_energy_sum;
        logic [COUNT_W-1:0]   largest_count;
        logic [OSUM_W-1:0]    largest_energy_sum;
        logic [TOTAL_W-1:0]   total_energy;
    } result_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_CLEAR,
        ST_READ,
        ST_CALC,
        ST_WRITE
    } state_t;

    typedef struct packed {
        logic latch;
        logic read;
        logic calc;
        logic write;
        logic sweep;
        logic wipe_excl;
        logic finish_clear;
    } ctl_t;

    typedef struct packed {
        logic sweep_last;
    } stat_t;

endpackage

>>> hdl/chea_ctrl.sv
// ----------------------------------------------------------------------------
// chea_ctrl
// Sequencer: power-up memory wipe, clear sweep and the read/update/write
// steps of every other command.
// ----------------------------------------------------------------------------
module chea_ctrl (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [chea_pkg::CMD_W-1:0]   cmd,
    input  chea_pkg::stat_t              stat,
    output chea_pkg::ctl_t               ctl,
    output logic                         busy
);
    import chea_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_INIT:
            begin
                if (stat.sweep_last)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    if (cmd == CMD_CLEAR)
                        state_next = ST_CLEAR;
                    else
                        state_next = ST_READ;
                end
            end
            ST_CLEAR:
            begin
                if (stat.sweep_last)
                    state_next = ST_IDLE;
            end
            ST_READ:  state_next = ST_CALC;
            ST_CALC:  state_next = ST_WRITE;
            ST_WRITE: state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        ctl              = '0;
        ctl.latch        = (state_reg == ST_IDLE) && start;
        ctl.read         = (state_reg == ST_READ);
        ctl.calc         = (state_reg == ST_CALC);
        ctl.write        = (state_reg == ST_WRITE);
        ctl.sweep        = (state_reg == ST_INIT) || (state_reg == ST_CLEAR);
        ctl.wipe_excl    = (state_reg == ST_INIT);
        ctl.finish_clear = (state_reg == ST_CLEAR) && stat.sweep_last;
        busy             = (state_reg != ST_IDLE);
    end

endmodule

>>> hdl/chea_datapath.sv
// ----------------------------------------------------------------------------
// chea_datapath
// Window registers, per-channel count, sum and exclusion memories, the
// saturating update and the result register.
// ----------------------------------------------------------------------------
module chea_datapath #(
    parameter int CHANNELS = chea_pkg::CHANNELS_DEF,
    parameter int SUM_BITS = chea_pkg::SUM_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  chea_pkg::hit_t                 item,
    input  logic                           cfg_we,
    input  logic [chea_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [chea_pkg::CFG_W-1:0]     cfg_data,
    input  chea_pkg::ctl_t                 ctl,
    output chea_pkg::stat_t                stat,
    output logic                           done,
    output chea_pkg::result_t              result
);
    import chea_pkg::*;

    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int SW    = ((SUM_BITS > EN_W) ? SUM_BITS : EN_W) + 1;
    localparam logic [SUM_BITS-1:0] SUM_LIM = {SUM_BITS{1'b1}};
    localparam logic [COUNT_W-1:0]  CNT_LIM = {COUNT_W{1'b1}};
    localparam logic [TOTAL_W-1:0]  TOT_LIM = {TOTAL_W{1'b1}};

    function automatic logic [OSUM_W-1:0] clip_out(input logic [SUM_BITS-1:0] v);
        logic [63:0] w;
        w = 64'(v);
        if (w > 64'h0000_0000_FFFF_FFFF)
            return 32'hFFFF_FFFF;
        return w[OSUM_W-1:0];
    endfunction

    // window registers
    logic [15:0] time_low_reg;
    logic [15:0] time_high_reg;
    logic [15:0] energy_low_reg;
    logic [16:0] energy_high_reg;
    logic [23:0] event_low_reg;
    logic [24:0] event_high_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_low_reg    <= TIME_LOW_RST;
            time_high_reg   <= TIME_HIGH_RST;
            energy_low_reg  <= ENERGY_LOW_RST;
            energy_high_reg <= ENERGY_HIGH_RST;
            event_low_reg   <= EVENT_LOW_RST;
            event_high_reg  <= EVENT_HIGH_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_TIME_LOW:    time_low_reg    <= cfg_data[15:0];
                REG_TIME_HIGH:   time_high_reg   <= cfg_data[15:0];
                REG_ENERGY_LOW:  energy_low_reg  <= cfg_data[15:0];
                REG_ENERGY_HIGH: energy_high_reg <= cfg_data[16:0];
                REG_EVENT_LOW:   event_low_reg   <= cfg_data[23:0];
                REG_EVENT_HIGH:  event_high_reg  <= cfg_data[24:0];
                default:
                begin
                end
            endcase
        end
    end

    // latched word
    logic [CMD_W-1:0]         cmd_reg;
    logic [CHAN_W-1:0]        chan_reg;
    logic [EN_W-1:0]          energy_reg;
    logic signed [TIME_W-1:0] time_reg;
    logic [EVT_W-1:0]         event_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.latch)
        begin
            cmd_reg    <= item.cmd;
            chan_reg   <= item.channel;
            energy_reg <= item.energy;
            time_reg   <= item.hit_time;
            event_reg  <= item.event_number;
        end
    end

    logic              in_range;
    logic [CHAN_W-1:0] chan_m1;
    logic [IDX_W-1:0]  idx;
    logic [IDX_W-1:0]  rd_idx;
    logic [IDX_W-1:0]  wr_idx;

    assign in_range = (chan_reg != '0) && ({1'b0, chan_reg} <= (CHAN_W + 1)'(CHANNELS));
    assign chan_m1  = chan_reg - CHAN_W'(1);
    assign idx      = chan_m1[IDX_W-1:0];
    assign rd_idx   = in_range ? idx : '0;

    // sweep counter for wipe and clear
    logic [IDX_W-1:0] sweep_idx_reg;
    logic             sweep_last;

    assign sweep_last      = (sweep_idx_reg == IDX_W'(CHANNELS - 1));
    assign stat.sweep_last = sweep_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sweep_idx_reg <= '0;
        end
        else if (ctl.sweep)
        begin
            if (sweep_last)
                sweep_idx_reg <= '0;
            else
                sweep_idx_reg <= sweep_idx_reg + IDX_W'(1);
        end
    end

    assign wr_idx = ctl.sweep ? sweep_idx_reg : idx;

    // window checks, registered with the memory read
    logic ev_ok;
    logic t_ok;
    logic e_ok;
    logic win_ok_reg;

    always_comb
    begin
        ev_ok = (event_reg >= event_low_reg)
             && (event_high_reg[24] || (event_reg <= event_high_reg[23:0]));
        t_ok  = time_high_reg[15]
             || ((time_reg >= $signed({time_low_reg, 4'b0000}))
              && (time_reg <= $signed({time_high_reg, 4'b0000})));
        e_ok  = energy_high_reg[16]
             || ((energy_reg >= {energy_low_reg, 4'b0000})
              && (energy_reg <= {energy_high_reg[15:0], 4'b0000}));
    end

    always_ff @(posedge clk)
    begin
        if (ctl.read)
            win_ok_reg <= ev_ok && t_ok && e_ok;
    end

    // per-channel memories
    logic [COUNT_W-1:0]  cnt_mem  [CHANNELS];
    logic [SUM_BITS-1:0] sum_mem  [CHANNELS];
    logic                excl_mem [CHANNELS];

    logic [COUNT_W-1:0]  rd_cnt_reg;
    logic [SUM_BITS-1:0] rd_sum_reg;
    logic                rd_excl_reg;

    logic acc_reg;
    logic stat_we;
    logic excl_we;
    logic excl_wdata;

    logic [COUNT_W-1:0]  new_cnt_reg;
    logic [SUM_BITS-1:0] new_sum_reg;
    logic [TOTAL_W-1:0]  new_total_reg;

    assign stat_we    = ctl.sweep || (ctl.write && acc_reg);
    assign excl_we    = (ctl.sweep && ctl.wipe_excl)
                     || (ctl.write && in_range
                         && ((cmd_reg == CMD_EXCLUDE) || (cmd_reg == CMD_INCLUDE)));
    assign excl_wdata = !ctl.sweep && (cmd_reg == CMD_EXCLUDE);

    always_ff @(posedge clk)
    begin
        if (stat_we)
            cnt_mem[wr_idx] <= ctl.sweep ? '0 : new_cnt_reg;
        if (ctl.read)
            rd_cnt_reg <= cnt_mem[rd_idx];
    end

    always_ff @(posedge clk)
    begin
        if (stat_we)
            sum_mem[wr_idx] <= ctl.sweep ? '0 : new_sum_reg;
        if (ctl.read)
            rd_sum_reg <= sum_mem[rd_idx];
    end

    always_ff @(posedge clk)
    begin
        if (excl_we)
            excl_mem[wr_idx] <= excl_wdata;
        if (ctl.read)
            rd_excl_reg <= excl_mem[rd_idx];
    end

    // saturating update
    logic [TOTAL_W-1:0] total_reg;
    logic [SW-1:0]      sum_wide;
    logic [TOTAL_W:0]   tot_wide;

    assign sum_wide = SW'(rd_sum_reg) + SW'(energy_reg);
    assign tot_wide = {1'b0, total_reg} + (TOTAL_W + 1)'(energy_reg);

    always_ff @(posedge clk)
    begin
        if (ctl.calc)
        begin
            acc_reg       <= (cmd_reg == CMD_RECORD) && in_range && !rd_excl_reg && win_ok_reg;
            new_cnt_reg   <= (rd_cnt_reg == CNT_LIM) ? CNT_LIM : rd_cnt_reg + COUNT_W'(1);
            new_sum_reg   <= (sum_wide > SW'(SUM_LIM)) ? SUM_LIM : sum_wide[SUM_BITS-1:0];
            new_total_reg <= tot_wide[TOTAL_W] ? TOT_LIM : tot_wide[TOTAL_W-1:0];
        end
    end

    // statistics and result
    logic [COUNT_W-1:0]  max_cnt_reg;
    logic [SUM_BITS-1:0] max_sum_reg;
    logic                done_reg;
    result_t             result_reg;

    logic [COUNT_W-1:0]  max_cnt_next;
    logic [SUM_BITS-1:0] max_sum_next;
    logic [TOTAL_W-1:0]  total_next;
    logic [COUNT_W-1:0]  ch_cnt;
    logic [SUM_BITS-1:0] ch_sum;

    always_comb
    begin
        max_cnt_next = max_cnt_reg;
        max_sum_next = max_sum_reg;
        total_next   = total_reg;
        if (acc_reg)
        begin
            if (new_cnt_reg > max_cnt_reg)
                max_cnt_next = new_cnt_reg;
            if (new_sum_reg > max_sum_reg)
                max_sum_next = new_sum_reg;
            total_next = new_total_reg;
        end
        ch_cnt = '0;
        ch_sum = '0;
        if (in_range)
        begin
            ch_cnt = acc_reg ? new_cnt_reg : rd_cnt_reg;
            ch_sum = acc_reg ? new_sum_reg : rd_sum_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_cnt_reg <= '0;
            max_sum_reg <= '0;
            total_reg   <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            done_reg <= ctl.write || ctl.finish_clear;
            if (ctl.finish_clear)
            begin
                max_cnt_reg <= '0;
                max_sum_reg <= '0;
                total_reg   <= '0;
            end
            else if (ctl.write)
            begin
                max_cnt_reg <= max_cnt_next;
                max_sum_reg <= max_sum_next;
                total_reg   <= total_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.finish_clear)
        begin
            result_reg <= '0;
        end
        else if (ctl.write)
        begin
            result_reg.accepted           <= acc_reg;
            result_reg.channel_count      <= ch_cnt;
            result_reg.channel_energy_sum <= clip_out(ch_sum);
            result_reg.largest_count      <= max_cnt_next;
            result_reg.largest_energy_sum <= clip_out(max_sum_next);
            result_reg.total_energy       <= total_next;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

>>> hdl/channel_hit_energy_accumulator_core.sv
// ----------------------------------------------------------------------------
// channel_hit_energy_accumulator_core
// Per-channel hit counter and energy histogrammer with event, time and
// energy windows and a channel exclusion map.
// ----------------------------------------------------------------------------
// Record, read, exclude and include commands pass through the read, calc and
// write states: the word is taken when start is high and busy low, the
// channel's memory entry is read, updated and written back, and the result
// shows for one cycle on done in the cycle in which busy is already low
// again, so the next word can be started then. The per-channel memories
// have one read and one write port, which sets this read-modify-write
// sequence. A clear command sweeps the count and sum memories one channel a
// cycle. After reset the block wipes all three memories and busy stays high
// until the wipe ends; register writes are taken during that time. Results
// cannot be held off, so done must be taken when it shows.
module channel_hit_energy_accumulator_core #(
    parameter int CHANNELS = chea_pkg::CHANNELS_DEF,
    parameter int SUM_BITS = chea_pkg::SUM_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  chea_pkg::hit_t                 item,
    output logic                           done,
    output chea_pkg::result_t              result,
    input  logic                           cfg_we,
    input  logic [chea_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [chea_pkg::CFG_W-1:0]     cfg_data
);
    import chea_pkg::*;

    ctl_t  ctl;
    stat_t stat;

    chea_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .cmd   (item.cmd),
        .stat  (stat),
        .ctl   (ctl),
        .busy  (busy)
    );

    chea_datapath #(
        .CHANNELS (CHANNELS),
        .SUM_BITS (SUM_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .ctl       (ctl),
        .stat      (stat),
        .done      (done),
        .result    (result)
    );

endmodule

>>> hdl/chea_checker.sv
// ----------------------------------------------------------------------------
// chea_checker
// Port-level checks of the accumulator's timing and result consistency.
// ----------------------------------------------------------------------------
module chea_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           start,
    input logic                           busy,
    input chea_pkg::hit_t                 item,
    input logic                           done,
    input chea_pkg::result_t              result
);
    import chea_pkg::*;

    // result word always lands in an idle cycle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result shown while busy");

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted word did not make the block busy");

    // a non-clear command accepted at start must end in a done pulse
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (item.cmd != CMD_CLEAR)) |-> ##4 done)
        else $error("result missing four cycles after start");

    a_largest: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ((result.channel_count <= result.largest_count)
               && (result.channel_energy_sum <= result.largest_energy_sum)))
        else $error("channel figure above the running maximum");

    a_acc_count: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.accepted) |-> (result.channel_count != '0))
        else $error("accepted hit left a zero count");

endmodule

bind channel_hit_energy_accumulator_core chea_checker u_chea_checker (.*);
